// ===== rtl/cam_pkg.sv =====
package cam_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int FRAC_BITS_DEF = 7;
  localparam int ANGLE_W       = 16;
  localparam int CNT_OUT_W     = 6;
  // signed work width: covers [-360 deg, 2^16) at up to 10 fraction bits, plus a sum bit
  localparam int WORK_W        = 21;

  typedef struct packed {
    logic wr;        // input beat accepted
    logic cap_cand;  // read data is the current candidate
    logic clr_acc;   // clear rank counters
    logic acc;       // read data is a scan element
    logic eval;      // check candidate rank
    logic finish;    // form result, close the set
  } cam_cmd_t;

endpackage

// ===== rtl/circular_angle_median_core.sv =====
// Median of a set of headings with wrap at 0/360 deg.
// Load: one sample beat per cycle while busy is low; a non-last beat does not raise busy.
// Last beat: busy during a rank search over the n stored samples
// (one memory read port scans every sample once per candidate); result strobes in the
// first cycle busy is low again, and the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the set and clears the strobe.
module circular_angle_median_core import cam_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ANGLE_W-1:0]   in_angle,
  input  logic                 in_last,
  output logic                 out_valid,
  output logic [ANGLE_W-1:0]   out_median,
  output logic [CNT_OUT_W-1:0] out_sample_count,
  output logic                 out_overflow
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // controller owns the candidate and scan loops; datapath holds store and counters
  cam_cmd_t      cmd;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] n;

  cam_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .n       (n),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  // candidate x is a median element when #(<x) <= k < #(<=x)
  cam_dp #(.CAPACITY(CAPACITY), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .in_angle         (in_angle),
    .n                (n),
    .out_valid        (out_valid),
    .out_median       (out_median),
    .out_sample_count (out_sample_count),
    .out_overflow     (out_overflow)
  );

endmodule

// ===== rtl/cam_ctrl.sv =====
module cam_ctrl import cam_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  input  logic [CW-1:0] n,
  output logic          busy,
  output cam_cmd_t      cmd,
  output logic [IW-1:0] rd_addr
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CAND = 6'b000010,
    S_SCAN = 6'b000100,
    S_TAIL = 6'b001000,
    S_EVAL = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          acc_r, cap_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_last) begin
          state_nxt = S_CAND;
          i_nxt     = '0;
        end
      end
      S_CAND: begin
        state_nxt = S_SCAN;
        j_nxt     = '0;
      end
      S_SCAN: begin
        j_nxt = j_r + 1'b1;
        if (j_r == n - 1'b1) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_EVAL;
      S_EVAL: begin
        i_nxt = i_r + 1'b1;
        if (i_r == n - 1'b1) state_nxt = S_FIN;
        else state_nxt = S_CAND;
      end
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      acc_r   <= 1'b0;
      cap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      acc_r   <= (state_r == S_SCAN);
      cap_r   <= (state_r == S_CAND);
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign rd_addr      = (state_r == S_CAND) ? i_r[IW-1:0] : j_r[IW-1:0];
  assign cmd.wr       = (state_r == S_IDLE) && start;
  assign cmd.cap_cand = cap_r;
  assign cmd.clr_acc  = (state_r == S_CAND);
  assign cmd.acc      = acc_r;
  assign cmd.eval     = (state_r == S_EVAL);
  assign cmd.finish   = (state_r == S_FIN);

endmodule

// ===== rtl/cam_dp.sv =====
module cam_dp import cam_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cam_cmd_t             cmd,
  input  logic [IW-1:0]        rd_addr,
  input  logic [ANGLE_W-1:0]   in_angle,
  output logic [CW-1:0]        n,
  output logic                 out_valid,
  output logic [ANGLE_W-1:0]   out_median,
  output logic [CNT_OUT_W-1:0] out_sample_count,
  output logic                 out_overflow
);

  localparam logic signed [WORK_W-1:0] D90  = WORK_W'(90 << FRAC_BITS);
  localparam logic signed [WORK_W-1:0] D180 = WORK_W'(180 << FRAC_BITS);
  localparam logic signed [WORK_W-1:0] D270 = WORK_W'(270 << FRAC_BITS);
  localparam logic signed [WORK_W-1:0] FULL = WORK_W'(360 << FRAC_BITS);

  logic [ANGLE_W-1:0] mem [CAPACITY];
  logic [ANGLE_W-1:0] rdata_r;

  logic [CW-1:0] cnt_r, outside_r, lt_r, le_r;
  logic          drop_r, shift;
  logic signed [WORK_W-1:0] folded, v, cand_r, lo_r, hi_r, sum, mean;
  logic [CW-1:0] k0, k1;
  logic          full, far;

  assign full = (cnt_r == CW'(CAPACITY));
  assign n    = cnt_r;

  // wrap once on arrival
  always_comb begin
    folded = WORK_W'(in_angle);
    if (folded >= FULL) folded = folded - FULL;
  end
  assign far = (folded < D90) || (folded > D270);

  // unwrap across 0/360 when most samples sit near north
  assign shift = outside_r > (cnt_r >> 1);
  always_comb begin
    v = WORK_W'(rdata_r);
    if (shift && v > D180 && v < FULL) v = v - FULL;
  end

  assign k0 = (cnt_r - 1'b1) >> 1;
  assign k1 = cnt_r >> 1;

  assign sum  = lo_r + hi_r;
  assign mean = cnt_r[0] ? lo_r : (sum >>> 1);

  always_ff @(posedge clk) begin
    if (cmd.wr && !full) mem[cnt_r[IW-1:0]] <= folded[ANGLE_W-1:0];
    rdata_r <= mem[rd_addr];
    if (cmd.cap_cand) cand_r <= v;
    if (cmd.eval) begin
      if (lt_r <= k0 && k0 < le_r) lo_r <= cand_r;
      if (lt_r <= k1 && k1 < le_r) hi_r <= cand_r;
    end
    if (cmd.finish) begin
      out_median       <= (mean < 0) ? ANGLE_W'(mean + FULL) : ANGLE_W'(mean);
      out_sample_count <= CNT_OUT_W'(cnt_r);
      out_overflow     <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      outside_r <= '0;
      drop_r    <= 1'b0;
      lt_r      <= '0;
      le_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.finish) begin
        cnt_r     <= '0;
        outside_r <= '0;
        drop_r    <= 1'b0;
      end else if (cmd.wr) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          if (far) outside_r <= outside_r + 1'b1;
        end
      end
      if (cmd.clr_acc) begin
        lt_r <= '0;
        le_r <= '0;
      end else if (cmd.acc) begin
        if (v < cand_r)  lt_r <= lt_r + 1'b1;
        if (v <= cand_r) le_r <= le_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cam_checker.sv =====
module cam_checker import cam_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_last,
  input logic                 out_valid,
  input logic [CNT_OUT_W-1:0] out_sample_count
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one beat");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_load_nobusy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last) |=> !busy) else $error("busy after non-last beat");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy) else $error("no search after last beat");

  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_count != '0)) else $error("empty set result");

endmodule

bind circular_angle_median_core cam_checker u_cam_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_sample_count (out_sample_count)
);
